@@ hdl/lta_pkg.sv @@
// Shared types, constants and sizes for the landmark track association block.
package lta_pkg;

    // Table and map sizes.
    localparam int CAND_DEPTH = 64;
    localparam int CAND_AW    = $clog2(CAND_DEPTH);
    localparam int CAND_CW    = $clog2(CAND_DEPTH + 1);
    localparam int MAP_DEPTH  = 256;
    localparam int MAP_CW     = $clog2(MAP_DEPTH + 1);

    // Field widths.
    localparam int POS_W   = 16;
    localparam int CLASS_W = 2;
    localparam int HITS_W  = 8;
    localparam int RAD_W   = 15;
    localparam int IDX_W   = 6;
    localparam int SLOT_W  = 8;

    // Shared multiplier operand and product widths.
    localparam int MUL_W  = 18;
    localparam int PROD_W = 2 * MUL_W;
    localparam int R2_W   = 2 * RAD_W;
    localparam int SQ_W   = 2 * POS_W;

    // Serial divider widths: dividend magnitude and divisor.
    localparam int DIV_W  = 26;
    localparam int DVS_W  = HITS_W + 1;
    localparam int DCNT_W = $clog2(DIV_W + 1);

    // Configuration register indexes.
    localparam int CFG_AW = 1;
    localparam int CFG_DW = RAD_W;
    localparam logic [CFG_AW-1:0] REG_MATCH_RADIUS     = 1'd0;
    localparam logic [CFG_AW-1:0] REG_CONFIRM_THRESHOLD = 1'd1;

    // Result action codes.
    typedef enum logic [1:0] {
        ACT_UPDATE    = 2'd0,
        ACT_CONFIRMED = 2'd1,
        ACT_NEW       = 2'd2,
        ACT_DROP      = 2'd3
    } t_action;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_R2,
        ST_SCAN,
        ST_DX,
        ST_DY,
        ST_CMP,
        ST_MX,
        ST_SX,
        ST_WX,
        ST_MY,
        ST_SY,
        ST_WY,
        ST_WRITE,
        ST_DONE
    } t_state;

    // One candidate table entry.
    typedef struct packed {
        logic [HITS_W-1:0]  hits;
        logic [CLASS_W-1:0] cls;
        logic [POS_W-1:0]   y;
        logic [POS_W-1:0]   x;
    } t_cand;

    // One result item.
    typedef struct packed {
        t_action           action;
        logic [IDX_W-1:0]  index;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [HITS_W-1:0] count;
        logic              promoted;
        logic [SLOT_W-1:0] slot;
        logic              full;
    } t_result;

    // Divider request and response.
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] quotient;
    } t_div_rsp;

endpackage

@@ hdl/landmark_track_association.sv @@
// Top level: landmark detection to candidate table association and refinement.
//
// Input stream: one detection per request, tdata holds x and y (signed Q7.8),
// tuser holds the colour class. Output stream: one result per detection,
// tuser holds the action code, tdata the slot, refined position, count and
// promotion fields. Configuration writes (match radius, confirm threshold)
// take effect at the clock edge where the write enable is high.
// One detection is worked at a time through a single shared 18x18 multiplier
// and a serial divider. After accept the radius is squared, then every table
// entry is compared in turn (address, memory read, two squares, compare);
// a new or dropped entry and an already confirmed entry then go straight to
// the result, while a running mean update takes two products and two
// 26-step divisions before the entry is written back. The sequencer returns
// to idle, where the next request is taken, as the result is registered.
// Reset clears the entry count, the map count and the output valid flag and
// restores the default radius and threshold; table contents are not cleared,
// since only entries below the count are ever used.
// A finished result waits in the output register; the next detection is
// accepted meanwhile, and a second result waits until the first is taken.
module landmark_track_association (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Detections.
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [31:0]                i_s_tdata,   // det_x[15:0], det_y[31:16]
    input  logic [1:0]                 i_s_tuser,   // det_class[1:0]
    // Results.
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [55:0]                o_m_tdata,   // entry_index[5:0], entry_x[21:6],
                                                    // entry_y[37:22], entry_count[45:38],
                                                    // promoted[46], map_slot[54:47],
                                                    // map_full[55]
    output logic [1:0]                 o_m_tuser,   // action[1:0]
    // Configuration.
    input  logic                       i_cfg_we,
    input  logic [lta_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [lta_pkg::CFG_DW-1:0] i_cfg_wdata
);
    import lta_pkg::*;

    // Registers.
    t_state              r_state, n_state;
    logic [POS_W-1:0]    r_det_x, n_det_x;
    logic [POS_W-1:0]    r_det_y, n_det_y;
    logic [CLASS_W-1:0]  r_det_class, n_det_class;
    logic [R2_W-1:0]     r_r2, n_r2;
    logic [CAND_CW-1:0]  r_idx, n_idx;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [SQ_W-1:0]     r_acc, n_acc;
    logic [POS_W-1:0]    r_new_x, n_new_x;
    logic [POS_W-1:0]    r_new_y, n_new_y;
    logic [CAND_CW-1:0]  r_cand_used, n_cand_used;
    logic [MAP_CW-1:0]   r_map_used, n_map_used;
    logic [RAD_W-1:0]    r_radius;
    logic [HITS_W-1:0]   r_thr;
    t_result             r_res, n_res;
    t_result             r_out, n_out;
    logic                r_out_valid, n_out_valid;

    // Candidate table.
    t_cand               mem [CAND_DEPTH];
    t_cand               r_rd;
    logic                mem_we;
    logic [CAND_AW-1:0]  mem_waddr;
    t_cand               mem_wdata;

    // Shared multiplier.
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;

    // Divider.
    t_div_req            div_req;
    t_div_rsp            div_rsp;

    logic [SQ_W:0]       dist2;
    logic [HITS_W-1:0]   hits_inc;

    lta_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Multiplier operand selection by state.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_R2: begin
                mul_a = MUL_W'(r_radius);
                mul_b = MUL_W'(r_radius);
            end
            ST_DX: begin
                mul_a = {{2{r_det_x[POS_W-1]}}, r_det_x} - {{2{r_rd.x[POS_W-1]}}, r_rd.x};
                mul_b = mul_a;
            end
            ST_DY: begin
                mul_a = {{2{r_det_y[POS_W-1]}}, r_det_y} - {{2{r_rd.y[POS_W-1]}}, r_rd.y};
                mul_b = mul_a;
            end
            ST_MX: begin
                mul_a = {{2{r_rd.x[POS_W-1]}}, r_rd.x};
                mul_b = MUL_W'(r_rd.hits);
            end
            ST_MY: begin
                mul_a = {{2{r_rd.y[POS_W-1]}}, r_rd.y};
                mul_b = MUL_W'(r_rd.hits);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = mul_a * mul_b;
    end

    // Squared distance of the current entry against the squared radius.
    assign dist2    = {1'b0, r_acc} + {1'b0, r_prod[SQ_W-1:0]};
    assign hits_inc = r_rd.hits + HITS_W'(1);

    // Sequencer: next state, datapath updates, table writes and divider requests.
    always_comb begin
        n_state     = r_state;
        n_det_x     = r_det_x;
        n_det_y     = r_det_y;
        n_det_class = r_det_class;
        n_r2        = r_r2;
        n_idx       = r_idx;
        n_prod      = r_prod;
        n_acc       = r_acc;
        n_new_x     = r_new_x;
        n_new_y     = r_new_y;
        n_cand_used = r_cand_used;
        n_map_used  = r_map_used;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_m_tready;
        mem_we      = 1'b0;
        mem_waddr   = r_idx[CAND_AW-1:0];
        mem_wdata   = '0;
        div_req     = '0;
        o_s_tready  = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_det_x     = i_s_tdata[15:0];
                    n_det_y     = i_s_tdata[31:16];
                    n_det_class = i_s_tuser[1:0];
                    n_state     = ST_R2;
                end
            end
            ST_R2: begin
                n_r2    = prod[R2_W-1:0];
                n_idx   = '0;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                // End of the used entries: open a new entry or drop.
                if (r_idx == r_cand_used) begin
                    n_res = '0;
                    if (r_cand_used < CAND_CW'(CAND_DEPTH)) begin
                        mem_we        = 1'b1;
                        mem_waddr     = r_cand_used[CAND_AW-1:0];
                        mem_wdata.x   = r_det_x;
                        mem_wdata.y   = r_det_y;
                        mem_wdata.cls = r_det_class;
                        mem_wdata.hits = HITS_W'(1);
                        n_cand_used   = r_cand_used + CAND_CW'(1);
                        n_res.action  = ACT_NEW;
                        n_res.index   = IDX_W'(r_cand_used);
                        n_res.x       = r_det_x;
                        n_res.y       = r_det_y;
                        n_res.count   = HITS_W'(1);
                    end else begin
                        n_res.action  = ACT_DROP;
                    end
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_DX;
                end
            end
            ST_DX: begin
                n_prod  = prod;
                n_state = ST_DY;
            end
            ST_DY: begin
                n_acc   = r_prod[SQ_W-1:0];
                n_prod  = prod;
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (dist2 < (SQ_W+1)'(r_r2)) begin
                    if (r_rd.hits < r_thr) begin
                        n_state = ST_MX;
                    end else begin
                        n_res        = '0;
                        n_res.action = ACT_CONFIRMED;
                        n_res.index  = IDX_W'(r_idx);
                        n_res.x      = r_rd.x;
                        n_res.y      = r_rd.y;
                        n_res.count  = r_rd.hits;
                        n_state      = ST_DONE;
                    end
                end else begin
                    n_idx   = r_idx + CAND_CW'(1);
                    n_state = ST_SCAN;
                end
            end
            ST_MX: begin
                n_prod  = prod;
                n_state = ST_SX;
            end
            ST_SX: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_prod[DIV_W-1:0]
                                 + {{(DIV_W-POS_W){r_det_x[POS_W-1]}}, r_det_x};
                div_req.divisor  = {1'b0, r_rd.hits} + DVS_W'(1);
                n_state          = ST_WX;
            end
            ST_WX: begin
                if (div_rsp.done) begin
                    n_new_x = div_rsp.quotient;
                    n_state = ST_MY;
                end
            end
            ST_MY: begin
                n_prod  = prod;
                n_state = ST_SY;
            end
            ST_SY: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_prod[DIV_W-1:0]
                                 + {{(DIV_W-POS_W){r_det_y[POS_W-1]}}, r_det_y};
                div_req.divisor  = {1'b0, r_rd.hits} + DVS_W'(1);
                n_state          = ST_WY;
            end
            ST_WY: begin
                if (div_rsp.done) begin
                    n_new_y = div_rsp.quotient;
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                // Store the refined entry and hand out a map slot on promotion.
                mem_we         = 1'b1;
                mem_wdata.x    = r_new_x;
                mem_wdata.y    = r_new_y;
                mem_wdata.cls  = r_rd.cls;
                mem_wdata.hits = hits_inc;
                n_res          = '0;
                n_res.action   = ACT_UPDATE;
                n_res.index    = IDX_W'(r_idx);
                n_res.x        = r_new_x;
                n_res.y        = r_new_y;
                n_res.count    = hits_inc;
                if (hits_inc == r_thr) begin
                    n_res.promoted = 1'b1;
                    if (r_map_used < MAP_CW'(MAP_DEPTH)) begin
                        n_res.slot = SLOT_W'(r_map_used);
                        n_map_used = r_map_used + MAP_CW'(1);
                    end else begin
                        n_res.slot = SLOT_W'(MAP_DEPTH - 1);
                        n_res.full = 1'b1;
                    end
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // Wait until the output register is free or being emptied.
                if (!r_out_valid || i_m_tready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand_used <= '0;
            r_map_used  <= '0;
            r_out_valid <= 1'b0;
            r_radius    <= RAD_W'(77);
            r_thr       <= HITS_W'(5);
        end else begin
            r_cand_used <= n_cand_used;
            r_map_used  <= n_map_used;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_MATCH_RADIUS:      r_radius <= i_cfg_wdata[RAD_W-1:0];
                    REG_CONFIRM_THRESHOLD: r_thr    <= i_cfg_wdata[HITS_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_det_x     <= n_det_x;
        r_det_y     <= n_det_y;
        r_det_class <= n_det_class;
        r_r2        <= n_r2;
        r_idx       <= n_idx;
        r_prod      <= n_prod;
        r_acc       <= n_acc;
        r_new_x     <= n_new_x;
        r_new_y     <= n_new_y;
        r_res       <= n_res;
        r_out       <= n_out;
    end

    // Candidate table: one write port, one registered read at the scan index.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= mem[r_idx[CAND_AW-1:0]];
    end

    // Output ports.
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.action;
    assign o_m_tdata  = {r_out.full, r_out.slot, r_out.promoted, r_out.count,
                         r_out.y, r_out.x, r_out.index};

`ifndef SYNTHESIS
    // The entry count never passes the table depth.
    a_cand_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cand_used <= CAND_CW'(CAND_DEPTH))
        else $error("candidate count beyond table depth");

    // The map count never passes the map depth.
    a_map_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_map_used <= MAP_CW'(MAP_DEPTH))
        else $error("map count beyond map depth");

    // The scan never runs past the used entries.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_idx <= r_cand_used))
        else $error("scan index beyond used entries");

    // Only an update can promote.
    a_promo_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[46]) |-> (o_m_tuser == ACT_UPDATE))
        else $error("promotion reported without an update");

    // A full map is only reported together with a promotion.
    a_full_promo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[55]) |-> o_m_tdata[46])
        else $error("map full without promotion");
`endif

endmodule

@@ hdl/lta_div.sv @@
// Serial restoring divider: signed dividend, unsigned divisor, truncates toward zero.
module lta_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lta_pkg::t_div_req i_req,
    output lta_pkg::t_div_rsp o_rsp
);
    import lta_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic              r_neg;
    logic [DCNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;

    logic [DVS_W:0]    shifted;
    logic              fits;
    logic [DIV_W-1:0]  signed_quo;

    // One quotient bit per cycle: shift in the next dividend bit and try the subtract.
    always_comb begin
        shifted    = {r_rem, r_quo[DIV_W-1]};
        fits       = (shifted >= {1'b0, r_dvs});
        signed_quo = r_neg ? (~r_quo + DIV_W'(1)) : r_quo;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= DCNT_W'(DIV_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - DCNT_W'(1);
            r_busy <= (r_cnt != DCNT_W'(1));
            r_done <= (r_cnt == DCNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    // Datapath: the dividend magnitude shifts out as the quotient shifts in.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.dividend[DIV_W-1];
            r_quo <= i_req.dividend[DIV_W-1] ? (~i_req.dividend + DIV_W'(1))
                                             : i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], fits};
            r_rem <= fits ? DVS_W'(shifted - {1'b0, r_dvs}) : shifted[DVS_W-1:0];
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = signed_quo[POS_W-1:0];

endmodule
